>>> rtl/js_string_escape_encoder_assert.svh
// ----------------------------------------------------------------------------
// JS string escape encoder assertion macros
// Shared property shorthands; the using scope provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef JS_STRING_ESCAPE_ENCODER_ASSERT_SVH
`define JS_STRING_ESCAPE_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Types, character codes and helpers shared by the escape encoder.
// ----------------------------------------------------------------------------
package jse_pkg;

	localparam int QUEUE_DEPTH = 4;

	// Characters
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_BS        = 8'h08;
	localparam logic [7:0] CH_FF        = 8'h0C;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_LOW_B     = 8'h62;
	localparam logic [7:0] CH_LOW_F     = 8'h66;
	localparam logic [7:0] CH_LOW_N     = 8'h6E;
	localparam logic [7:0] CH_LOW_R     = 8'h72;
	localparam logic [7:0] CH_LOW_T     = 8'h74;
	localparam logic [7:0] CH_LOW_U     = 8'h75;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_PRINT_LO  = 8'h20;
	localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

	// Body kinds of a descriptor
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_PASS = 2'd1;
	localparam logic [1:0] KIND_PAIR = 2'd2;
	localparam logic [1:0] KIND_UNI  = 2'd3;

	// Escape run for one input word
	typedef struct packed {
		logic       open_q;   // leading quote
		logic       close_q;  // trailing quote
		logic [1:0] kind;
		logic [7:0] body;     // pass byte, pair second byte, or raw byte for \u00XX
		logic       str_end;
		logic [3:0] count;    // total bytes in the run, 1..8
	} desc_t;

	function automatic logic [2:0] body_len(input logic [1:0] kind);
		logic [2:0] len;
		case (kind)
			KIND_NONE: len = 3'd0;
			KIND_PASS: len = 3'd1;
			KIND_PAIR: len = 3'd2;
			KIND_UNI:  len = 3'd6;
			default:   len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
	endfunction

endpackage

>>> rtl/jse_in_if.sv
// ----------------------------------------------------------------------------
// jse_in_if
// Input channel: one source byte with string markers.
// ----------------------------------------------------------------------------
interface jse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       first_byte;
	logic       last_byte;
	logic       empty_string;
	logic       with_quotes;

	modport source (output valid, char_byte, first_byte, last_byte, empty_string,
		with_quotes, input ready);
	modport sink (input valid, char_byte, first_byte, last_byte, empty_string,
		with_quotes, output ready);
endinterface

>>> rtl/jse_out_if.sv
// ----------------------------------------------------------------------------
// jse_out_if
// Output channel: one byte of escaped text with run markers.
// ----------------------------------------------------------------------------
interface jse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_end;

	modport source (output valid, out_byte, run_last, string_end, input ready);
	modport sink (input valid, out_byte, run_last, string_end, output ready);
endinterface

>>> rtl/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// Accept input words and classify each into an escape-run descriptor.
// ----------------------------------------------------------------------------
module jse_front (
	jse_in_if.sink         in_ch,
	input  logic           full,
	output logic           push,
	output jse_pkg::desc_t desc
);

	logic [1:0] kind;
	logic [7:0] body;
	logic       quotes;
	logic       open_q;
	logic       close_q;
	logic [2:0] blen;

	assign in_ch.ready = !full;
	assign quotes      = in_ch.with_quotes;

	always_comb begin
		kind = jse_pkg::KIND_PASS;
		body = in_ch.char_byte;
		case (in_ch.char_byte)
			jse_pkg::CH_QUOTE: begin
				kind = jse_pkg::KIND_PAIR;
				body = jse_pkg::CH_QUOTE;
			end
			jse_pkg::CH_BACKSLASH: begin
				kind = jse_pkg::KIND_PAIR;
				body = jse_pkg::CH_BACKSLASH;
			end
			jse_pkg::CH_BS: begin
				kind = jse_pkg::KIND_PAIR;
				body = jse_pkg::CH_LOW_B;
			end
			jse_pkg::CH_FF: begin
				kind = jse_pkg::KIND_PAIR;
				body = jse_pkg::CH_LOW_F;
			end
			jse_pkg::CH_LF: begin
				kind = jse_pkg::KIND_PAIR;
				body = jse_pkg::CH_LOW_N;
			end
			jse_pkg::CH_CR: begin
				kind = jse_pkg::KIND_PAIR;
				body = jse_pkg::CH_LOW_R;
			end
			jse_pkg::CH_TAB: begin
				kind = jse_pkg::KIND_PAIR;
				body = jse_pkg::CH_LOW_T;
			end
			default: begin
				if (!(in_ch.char_byte inside
						{[jse_pkg::CH_PRINT_LO:jse_pkg::CH_PRINT_HI]})) begin
					kind = jse_pkg::KIND_UNI;
				end
			end
		endcase
		// empty string: only the two quotes
		if (in_ch.empty_string) begin
			kind = jse_pkg::KIND_NONE;
		end
	end

	assign open_q  = quotes && (in_ch.empty_string || in_ch.first_byte);
	assign close_q = quotes && (in_ch.empty_string || in_ch.last_byte);
	assign blen    = jse_pkg::body_len(kind);

	always_comb begin
		desc.open_q  = open_q;
		desc.close_q = close_q;
		desc.kind    = kind;
		desc.body    = body;
		desc.str_end = in_ch.empty_string || in_ch.last_byte;
		desc.count   = {1'b0, blen} + {3'd0, open_q} + {3'd0, close_q};
	end

	// drop empty strings without quotes: they produce nothing
	assign push = in_ch.valid && !full && !(in_ch.empty_string && !quotes);

endmodule

>>> rtl/jse_fifo.sv
// ----------------------------------------------------------------------------
// jse_fifo
// Short descriptor queue between the classifier and the expander.
// ----------------------------------------------------------------------------
module jse_fifo #(
	parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jse_pkg::desc_t wr_desc,
	input  logic           pop,
	output logic           full,
	output logic           head_vld,
	output jse_pkg::desc_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jse_pkg::desc_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && head_vld;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// Expand the head descriptor into output bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module jse_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_vld,
	input  jse_pkg::desc_t head,
	output logic           pop,
	output logic [2:0]     idx,
	jse_out_if.source      out_ch
);

	logic [2:0] idx_q;
	logic       out_vld_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       string_end_q;
	logic       step;
	logic       cur_last;
	logic [2:0] blen;
	logic [2:0] bpos;
	logic [7:0] cur_byte;

	assign blen     = jse_pkg::body_len(head.kind);
	assign bpos     = idx_q - {2'd0, head.open_q};
	assign cur_last = ({1'b0, idx_q} == head.count - 4'd1);
	assign step     = head_vld && (!out_vld_q || out_ch.ready);
	assign pop      = step && cur_last;
	assign idx      = idx_q;

	always_comb begin
		cur_byte = jse_pkg::CH_QUOTE;
		if (head.open_q && idx_q == 3'd0) begin
			cur_byte = jse_pkg::CH_QUOTE;
		end else if (bpos < blen) begin
			case (head.kind)
				jse_pkg::KIND_PASS: begin
					cur_byte = head.body;
				end
				jse_pkg::KIND_PAIR: begin
					cur_byte = (bpos == 3'd0) ? jse_pkg::CH_BACKSLASH : head.body;
				end
				jse_pkg::KIND_UNI: begin
					case (bpos)
						3'd0:    cur_byte = jse_pkg::CH_BACKSLASH;
						3'd1:    cur_byte = jse_pkg::CH_LOW_U;
						3'd2:    cur_byte = jse_pkg::CH_ZERO;
						3'd3:    cur_byte = jse_pkg::CH_ZERO;
						3'd4:    cur_byte = jse_pkg::hex_char(head.body[7:4]);
						default: cur_byte = jse_pkg::hex_char(head.body[3:0]);
					endcase
				end
				default: begin
					cur_byte = jse_pkg::CH_QUOTE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q   <= cur_byte;
			run_last_q   <= cur_last;
			string_end_q <= cur_last && head.str_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (step) begin
				out_vld_q <= 1'b1;
				idx_q     <= cur_last ? 3'd0 : idx_q + 3'd1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid      = out_vld_q;
	assign out_ch.out_byte   = out_byte_q;
	assign out_ch.run_last   = run_last_q;
	assign out_ch.string_end = string_end_q;

endmodule

>>> rtl/js_string_escape_encoder.sv
// ----------------------------------------------------------------------------
// js_string_escape_encoder
// JavaScript string-literal escaper: one source byte in, its escaped run out.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Payload                                               Handshake
// in_ch    in   char_byte, first_byte, last_byte, empty_string,       valid/ready
//               with_quotes
// out_ch   out  out_byte, run_last, string_end                        valid/ready
//
// Each input word turns into a run of 0 to 8 output words; the back end
// emits one output word per cycle while the output is ready; a run is 1
// word long for an unquoted plain byte and 8 at most.
// Plain bytes flow at one word per cycle while the output is ready.
// A QUEUE_DEPTH-entry descriptor queue decouples the two sides: input
// stalls only when the queue is full, output stalls only stall expansion.
// Reset clears queue pointers, the expansion index and the output valid.
//
module js_string_escape_encoder #(
	parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	jse_in_if.sink     in_ch,
	jse_out_if.source  out_ch
);

`include "js_string_escape_encoder_assert.svh"

	jse_pkg::desc_t wr_desc;
	jse_pkg::desc_t head;
	logic           push;
	logic           pop;
	logic           full;
	logic           head_vld;
	logic [2:0]     idx;

	// Classify each accepted word into a descriptor (quotes, body kind, length)
	jse_front u_front (
		.in_ch (in_ch),
		.full  (full),
		.push  (push),
		.desc  (wr_desc)
	);

	// Hold pending descriptors while the expander works through longer runs
	jse_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_desc  (wr_desc),
		.pop      (pop),
		.full     (full),
		.head_vld (head_vld),
		.head     (head)
	);

	// Walk the head descriptor one byte per unstalled cycle into the output register
	jse_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_vld (head_vld),
		.head     (head),
		.pop      (pop),
		.idx      (idx),
		.out_ch   (out_ch)
	);

	// Assertions
	`JSE_ASSERT_NOW(a_end_on_run_last, out_ch.valid && out_ch.string_end, out_ch.run_last, "string end without run last")
	`JSE_ASSERT_NOW(a_drop_silent, in_ch.valid && in_ch.ready && in_ch.empty_string && !in_ch.with_quotes, !push, "unquoted empty string queued")
	`JSE_ASSERT_NOW(a_idx_in_run, head_vld, {1'b0, idx} < head.count, "expansion index past run length")
	`JSE_ASSERT_NEXT(a_out_after_pop, pop, out_ch.valid && out_ch.run_last, "run end not presented")

endmodule

>>> dv/tb_js_string_escape_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_js_string_escape_encoder
// Drives source words with string markers into the escape encoder and checks
// every escaped output word against a predicted run, with random input gaps
// and random back-pressure on the output channel.
// ----------------------------------------------------------------------------
module tb_js_string_escape_encoder;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_WORDS = 260;
	localparam int SETTLE_CYCLES = 20;
	// ASCII digits for the \u00XX escape, digit for nibble value 0 in the top byte
	localparam logic [127:0] HEX_ASCII = "0123456789ABCDEF";

	// One source word as queued for the driver; hold_for_drain makes the
	// driver wait until every escaped word predicted so far has come out.
	typedef struct packed {
		logic [7:0] char_byte;
		logic       first_byte;
		logic       last_byte;
		logic       empty_string;
		logic       with_quotes;
		logic       hold_for_drain;
	} src_word_t;

	// One word of escaped text
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_end;
	} esc_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	jse_in_if  in_ch ();
	jse_out_if out_ch ();

	js_string_escape_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #1 clk = ~clk;

	src_word_t pending_words[$];   // stimulus not yet offered to the block
	esc_word_t escaped_text[$];    // predicted output, oldest first

	src_word_t offered;            // word currently on the input channel
	esc_word_t want;
	int        burst_left;
	int        gap_left;
	int        predicted_total;    // driver side only
	int        received_total;     // updated with NBA by the monitor
	int        words_accepted;
	int        strings_closed;
	int        empty_strings;
	int        unicode_escapes;
	int        pair_escapes;
	int        errors;
	int        cycle_count;

	// Receiver stall pattern state
	int        stall_mode;
	int        mode_left;
	int        stall_left;
	int        phase_cnt;
	logic      next_ready;

	// ------------------------------------------------------------------------
	// Escape prediction: build the byte run for one accepted word, then mark
	// its final byte with run_last and, when the word closes a string,
	// string_end. An empty string without quoting yields no bytes at all.
	// ------------------------------------------------------------------------
	function automatic void predict_escape(input src_word_t w);
		logic [7:0] run_bytes[$];
		logic [7:0] pair_char;
		logic       is_pair;
		esc_word_t  ew;

		pair_char = jse_pkg::CH_QUOTE;
		is_pair = 1'b1;
		if (w.empty_string) begin
			empty_strings++;
			if (w.with_quotes) begin
				run_bytes.push_back(jse_pkg::CH_QUOTE);
				run_bytes.push_back(jse_pkg::CH_QUOTE);
			end
		end else begin
			if (w.first_byte && w.with_quotes)
				run_bytes.push_back(jse_pkg::CH_QUOTE);
			case (w.char_byte)
				jse_pkg::CH_QUOTE:     pair_char = jse_pkg::CH_QUOTE;
				jse_pkg::CH_BACKSLASH: pair_char = jse_pkg::CH_BACKSLASH;
				jse_pkg::CH_BS:        pair_char = jse_pkg::CH_LOW_B;
				jse_pkg::CH_FF:        pair_char = jse_pkg::CH_LOW_F;
				jse_pkg::CH_LF:        pair_char = jse_pkg::CH_LOW_N;
				jse_pkg::CH_CR:        pair_char = jse_pkg::CH_LOW_R;
				jse_pkg::CH_TAB:       pair_char = jse_pkg::CH_LOW_T;
				default:               is_pair = 1'b0;
			endcase
			if (is_pair) begin
				pair_escapes++;
				run_bytes.push_back(jse_pkg::CH_BACKSLASH);
				run_bytes.push_back(pair_char);
			end else if (!(w.char_byte inside
					{[jse_pkg::CH_PRINT_LO:jse_pkg::CH_PRINT_HI]})) begin
				// no UTF-8 decoding: every such byte gets its own \u00XX
				unicode_escapes++;
				run_bytes.push_back(jse_pkg::CH_BACKSLASH);
				run_bytes.push_back(jse_pkg::CH_LOW_U);
				run_bytes.push_back(jse_pkg::CH_ZERO);
				run_bytes.push_back(jse_pkg::CH_ZERO);
				run_bytes.push_back(HEX_ASCII[8 * (15 - w.char_byte[7:4]) +: 8]);
				run_bytes.push_back(HEX_ASCII[8 * (15 - w.char_byte[3:0]) +: 8]);
			end else begin
				run_bytes.push_back(w.char_byte);
			end
			if (w.last_byte && w.with_quotes)
				run_bytes.push_back(jse_pkg::CH_QUOTE);
			if (w.last_byte)
				strings_closed++;
		end
		foreach (run_bytes[i]) begin
			ew.out_byte = run_bytes[i];
			ew.run_last = (i == run_bytes.size() - 1);
			ew.string_end = ew.run_last && (w.last_byte || w.empty_string);
			escaped_text.push_back(ew);
			predicted_total++;
		end
	endfunction

	// Pick a source byte, weighted toward the bytes that need escaping.
	function automatic logic [7:0] rand_source_char();
		int k;
		logic [7:0] c;

		k = $urandom_range(0, 9);
		if (k < 4) begin
			c = 8'($urandom_range(32, 126));
		end else if (k < 6) begin
			case ($urandom_range(0, 6))
				0:       c = jse_pkg::CH_QUOTE;
				1:       c = jse_pkg::CH_BACKSLASH;
				2:       c = jse_pkg::CH_BS;
				3:       c = jse_pkg::CH_FF;
				4:       c = jse_pkg::CH_LF;
				5:       c = jse_pkg::CH_CR;
				default: c = jse_pkg::CH_TAB;
			endcase
		end else if (k < 8) begin
			c = 8'($urandom_range(0, 31));
		end else begin
			c = 8'($urandom_range(127, 255));
		end
		return c;
	endfunction

	task automatic add_word(input logic [7:0] c, input logic f, input logic l,
		input logic e, input logic q, input logic d);
		src_word_t w;

		w.char_byte = c;
		w.first_byte = f;
		w.last_byte = l;
		w.empty_string = e;
		w.with_quotes = q;
		w.hold_for_drain = d;
		pending_words.push_back(w);
	endtask

	// ------------------------------------------------------------------------
	// Driver: offer words in bursts of random length with random gaps.
	// Predict each word at the edge where it is accepted. Hold a word on the
	// channel until ready; never drop valid between back-to-back words.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.char_byte <= 8'h00;
			in_ch.first_byte <= 1'b0;
			in_ch.last_byte <= 1'b0;
			in_ch.empty_string <= 1'b0;
			in_ch.with_quotes <= 1'b0;
			burst_left = 0;
			gap_left = 0;
			predicted_total = 0;
			words_accepted = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_escape(offered);
				words_accepted++;
			end
			if (in_ch.valid && !in_ch.ready) begin
				// hold the current word
			end else if (gap_left > 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (pending_words.size() == 0 ||
				(pending_words[0].hold_for_drain && received_total < predicted_total)) begin
				// nothing to send, or drain the output before this word
				in_ch.valid <= 1'b0;
			end else begin
				offered = pending_words.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.char_byte <= offered.char_byte;
				in_ch.first_byte <= offered.first_byte;
				in_ch.last_byte <= offered.last_byte;
				in_ch.empty_string <= offered.empty_string;
				in_ch.with_quotes <= offered.with_quotes;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// end of burst: sometimes a long gap-free stretch follows
					if ($urandom_range(0, 7) == 0) begin
						burst_left = $urandom_range(32, 64);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: compare each accepted output word with the oldest prediction,
	// then choose ready for the next cycle from the current stall pattern.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			received_total <= 0;
			stall_mode = 0;
			mode_left = 0;
			stall_left = 0;
			phase_cnt = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (escaped_text.size() == 0) begin
					$display("%0t: extra word: expected none, actual %02h/%0b/%0b",
						$time, out_ch.out_byte, out_ch.run_last, out_ch.string_end);
					errors++;
				end else begin
					want = escaped_text.pop_front();
					if (out_ch.out_byte !== want.out_byte) begin
						$display("%0t: out_byte mismatch: expected %02h, actual %02h",
							$time, want.out_byte, out_ch.out_byte);
						errors++;
					end
					if (out_ch.run_last !== want.run_last) begin
						$display("%0t: run_last mismatch: expected %0b, actual %0b",
							$time, want.run_last, out_ch.run_last);
						errors++;
					end
					if (out_ch.string_end !== want.string_end) begin
						$display("%0t: string_end mismatch: expected %0b, actual %0b",
							$time, want.string_end, out_ch.string_end);
						errors++;
					end
				end
				received_total <= received_total + 1;
			end

			// switch stall pattern when the current one has run its course
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left--;
			end
			phase_cnt++;
			case (stall_mode)
				0: next_ready = 1'b1;
				1: next_ready = ($urandom_range(0, 2) != 0);
				2: next_ready = (phase_cnt % 4 != 0);
				default: begin
					// long stalls separated by short open windows
					if (stall_left > 0) begin
						stall_left--;
						next_ready = 1'b0;
					end else if ($urandom_range(0, 5) == 0) begin
						stall_left = $urandom_range(1, 8);
						next_ready = 1'b0;
					end else begin
						next_ready = 1'b1;
					end
				end
			endcase
			out_ch.ready <= next_ready;
		end
	end

	// Abort the run if it hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still pending",
				cycle_count, escaped_text.size());
			$display("js_string_escape_encoder verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		logic [7:0] dir_bytes[14];
		int         counted;
		int         len;
		int         pick;
		logic       q;
		logic       drop_first;
		logic       drop_last;
		logic       drain_next;

		errors = 0;
		cycle_count = 0;
		arst_n <= 1'b0;

		// Directed: empty strings with and without quoting, and the longest
		// run (quoted one-byte string needing a \u00XX escape).
		add_word(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
		add_word(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
		add_word(8'h80, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);

		// Directed: one quoted string over every pair escape, both edges of
		// the printable range and the byte extremes.
		dir_bytes = '{jse_pkg::CH_QUOTE, jse_pkg::CH_BACKSLASH, jse_pkg::CH_BS,
			jse_pkg::CH_FF, jse_pkg::CH_LF, jse_pkg::CH_CR, jse_pkg::CH_TAB,
			8'h00, 8'h1F, jse_pkg::CH_PRINT_LO, jse_pkg::CH_PRINT_HI,
			8'h7F, 8'hFF, 8'h41};
		foreach (dir_bytes[i])
			add_word(dir_bytes[i], i == 0, i == 13, 1'b0, 1'b1, 1'b0);

		// Directed: unquoted single byte, missing markers, quoting flag
		// flipping inside a string, and a word that waits for a drained output.
		add_word(jse_pkg::CH_BACKSLASH, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
		add_word(8'h61, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
		add_word(jse_pkg::CH_LF, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
		add_word(8'h7F, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
		add_word(8'h42, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
		add_word(jse_pkg::CH_QUOTE, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);

		// Random: mostly well-formed strings, the rest empty strings, broken
		// strings and noise. Quoted-off empty strings do not count.
		counted = 0;
		drain_next = 1'b1;
		while (counted < RANDOM_WORDS) begin
			pick = $urandom_range(0, 99);
			q = 1'($urandom_range(0, 1));
			if (pick < 70) begin
				len = ($urandom_range(0, 4) == 0) ?
					$urandom_range(5, 12) : $urandom_range(1, 4);
				for (int i = 0; i < len; i++)
					add_word(rand_source_char(), i == 0, i == len - 1, 1'b0, q,
						i == 0 && drain_next);
				counted += len;
				drain_next = ($urandom_range(0, 19) == 0);
			end else if (pick < 80) begin
				add_word(8'($urandom), 1'($urandom), 1'($urandom), 1'b1, q, 1'b0);
				if (q)
					counted++;
			end else if (pick < 90) begin
				len = $urandom_range(2, 5);
				drop_first = 1'($urandom);
				drop_last = !drop_first || ($urandom_range(0, 1) == 0);
				for (int i = 0; i < len; i++) begin
					add_word(rand_source_char(), i == 0 && !drop_first,
						i == len - 1 && !drop_last, 1'b0, q, 1'b0);
					// sometimes flip quoting mid-string
					if ($urandom_range(0, 3) == 0)
						q = !q;
				end
				counted += len;
			end else begin
				add_word(rand_source_char(), 1'($urandom), 1'($urandom),
					$urandom_range(0, 3) == 0, q, 1'b0);
				counted++;
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Wait for all stimulus to go in and all predictions to come out.
		while (pending_words.size() != 0 || in_ch.valid) @(negedge clk);
		while (received_total < predicted_total) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (escaped_text.size() != 0) begin
			$display("%0t: missing output: expected %0d more words, actual none",
				$time, escaped_text.size());
			errors++;
		end

		$display("run covered %0d source words: %0d strings closed, %0d empty strings",
			words_accepted, strings_closed, empty_strings);
		$display("%0d escaped words compared, %0d pair and %0d unicode escapes, %0d errors",
			received_total, pair_escapes, unicode_escapes, errors);
		if (errors == 0)
			$display("js_string_escape_encoder verification clean");
		else
			$display("js_string_escape_encoder verification failed");
		$finish;
	end

endmodule
